// File: sv/lrkm_pkg.sv
// Package for the line response keyword matcher.
// Holds the shared sizes, opcode and outcome codes, register indexes and the
// configuration struct. It depends on nothing else.
package lrkm_pkg;

   localparam int LINE_CAPACITY = 512;
   localparam int MAX_KEYWORD   = 16;
   localparam int COUNT_W       = $clog2(LINE_CAPACITY);
   localparam int KEYWORD_BYTES = 16;
   localparam int KW_LEN_W      = 5;
   localparam int TICK_W        = 32;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;

   localparam logic [COUNT_W-1:0] LINE_FULL = COUNT_W'(LINE_CAPACITY - 1);
   localparam logic [KW_LEN_W-1:0] KW_LEN_MAX = KW_LEN_W'(MAX_KEYWORD);

   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   // Newest character sits in the lowest byte of the window.
   localparam logic [4:0][7:0] ERR_WINDOW = "ERROR";

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      OUT_OK      = 2'd0,
      OUT_ERROR   = 2'd1,
      OUT_TIMEOUT = 2'd2
   } outcome_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KEYWORD_LOW  = 3'd0,
      REG_KEYWORD_HIGH = 3'd1,
      REG_KEYWORD_LEN  = 3'd2,
      REG_KEYWORD_EN   = 3'd3,
      REG_TIMEOUT      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [KEYWORD_BYTES-1:0][7:0] keyword;
      logic [KW_LEN_W-1:0]           keyword_length;
      logic                          keyword_enable;
      logic [TICK_W-1:0]             timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic               active;
      logic [COUNT_W-1:0] stored_count;
      logic               result_load;
   } status_type;

endpackage

// File: sv/line_response_keyword_matcher.sv
// Top level of the line response keyword matcher.
// Depends on lrkm_pkg and instantiates lrkm_csr and lrkm_core.
//
// After a start transfer the block watches received bytes line by line and
// reports OK when the configured keyword occurred in a line, ERROR when the
// line held the text ERROR, or TIMEOUT when the idle tick count reaches the
// programmed limit. For every request transfer the line state and a 16 byte
// character window are updated by one pass of comparators, and any outcome
// lands in the result register on the clock edge that accepts the request. A
// new request is taken in every cycle while the result register is empty or
// being drained, so the sustained rate is one request per cycle.
// Configuration writes are taken in any cycle and must only be made while
// no wait is in progress.
module line_response_keyword_matcher (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] data_byte
   input  logic [1:0]                          req_tuser,  // [1:0] opcode
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [1:0] outcome, rest zero
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lrkm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lrkm_pkg::CSR_DATA_W-1:0]     csr_data
);
   import lrkm_pkg::*;

   cfg_type     cfg;
   status_type  status;
   logic        req_accept;
   logic        rsp_valid;
   outcome_type rsp_outcome;

   assign req_tready = !rsp_valid || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   lrkm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lrkm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_accept  (req_accept),
      .req_opcode  (opcode_type'(req_tuser)),
      .req_byte    (req_tdata),
      .rsp_taken   (rsp_tready),
      .rsp_valid   (rsp_valid),
      .rsp_outcome (rsp_outcome),
      .status      (status)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {6'b0, rsp_outcome};

   // Any reported outcome ends the wait.
   a_result_ends_wait: assert property (@(posedge clock) disable iff (reset)
      status.result_load |=> !status.active)
      else $error("wait still active after an outcome was reported");

   // The stored character count never passes the line capacity.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      status.stored_count <= LINE_FULL)
      else $error("stored character count beyond line capacity");

   // A start with a nonzero timeout opens a wait and reports nothing.
   a_start_opens_wait: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == OP_START && cfg.timeout_ticks != '0)
         |=> (status.active && status.stored_count == '0))
      else $error("start transfer did not open a clean wait");

   // A new outcome only enters the result register when it is free or drained.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (status.result_load && rsp_valid) |-> rsp_tready)
      else $error("pending outcome overwritten");

endmodule

// File: sv/lrkm_csr.sv
// Configuration registers of the line response keyword matcher.
// Depends on lrkm_pkg; the keyword length is clamped to MAX_KEYWORD on write.
module lrkm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lrkm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lrkm_pkg::CSR_DATA_W-1:0]    csr_data,
   output lrkm_pkg::cfg_type                  cfg
);
   import lrkm_pkg::*;

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic [KW_LEN_W-1:0] len_raw;

   assign csr_ready = 1'b1;
   assign len_raw   = csr_data[KW_LEN_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_KEYWORD_LOW:  cfg_in.keyword[7:0]  = csr_data;
            REG_KEYWORD_HIGH: cfg_in.keyword[15:8] = csr_data;
            REG_KEYWORD_LEN:  cfg_in.keyword_length =
                                 (len_raw > KW_LEN_MAX) ? KW_LEN_MAX : len_raw;
            REG_KEYWORD_EN:   cfg_in.keyword_enable = csr_data[0];
            REG_TIMEOUT:      cfg_in.timeout_ticks = csr_data[TICK_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.keyword        <= '0;
         cfg_ff.keyword_length <= KW_LEN_W'(2);
         cfg_ff.keyword_enable <= 1'b1;
         cfg_ff.timeout_ticks  <= TICK_W'(1000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/lrkm_match.sv
// Window comparators of the line response keyword matcher.
// Depends on lrkm_pkg; checks the updated character window for the keyword
// and for the text ERROR.
module lrkm_match (
   input  logic [lrkm_pkg::MAX_KEYWORD-1:0][7:0] window,
   input  logic [lrkm_pkg::COUNT_W-1:0]          count,
   input  lrkm_pkg::cfg_type                     cfg,
   output logic                                  keyword_hit,
   output logic                                  error_hit
);
   import lrkm_pkg::*;

   logic [MAX_KEYWORD-1:0] pos_ok;
   logic [KW_LEN_W-1:0]    sel;
   logic [7:0]             expected;

   // Window byte j must equal keyword byte (length - 1 - j) for j below length.
   always_comb begin
      pos_ok = '0;
      for (int j = 0; j < MAX_KEYWORD; j++) begin
         sel       = cfg.keyword_length - KW_LEN_W'(j + 1);
         expected  = cfg.keyword[sel[$clog2(KEYWORD_BYTES)-1:0]];
         pos_ok[j] = (KW_LEN_W'(j) >= cfg.keyword_length) || (window[j] == expected);
      end
   end

   assign keyword_hit = (cfg.keyword_length != '0)
                     && (count >= COUNT_W'(cfg.keyword_length))
                     && (&pos_ok);

   assign error_hit = (count >= COUNT_W'(5)) && (window[4:0] == ERR_WINDOW);

endmodule

// File: sv/lrkm_core.sv
// Line state, idle counter and result register of the line response keyword
// matcher. Depends on lrkm_pkg and instantiates lrkm_match.
module lrkm_core (
   input  logic                     clock,
   input  logic                     reset,
   input  lrkm_pkg::cfg_type        cfg,
   input  logic                     req_accept,
   input  lrkm_pkg::opcode_type     req_opcode,
   input  logic [7:0]               req_byte,
   input  logic                     rsp_taken,
   output logic                     rsp_valid,
   output lrkm_pkg::outcome_type    rsp_outcome,
   output lrkm_pkg::status_type     status
);
   import lrkm_pkg::*;

   logic                          active_ff, active_in;
   logic [MAX_KEYWORD-1:0][7:0]   window_ff, window_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic                          kw_seen_ff, kw_seen_in;
   logic                          err_seen_ff, err_seen_in;
   logic                          nul_seen_ff, nul_seen_in;
   logic [TICK_W-1:0]             idle_ff, idle_in;
   logic                          valid_ff, valid_in;
   outcome_type                   outcome_ff, outcome_in;

   logic [MAX_KEYWORD-1:0][7:0]   window_shift;
   logic [COUNT_W-1:0]            count_plus;
   logic                          keyword_hit;
   logic                          error_hit;
   logic                          result_load;
   outcome_type                   result_code;

   assign window_shift = {window_ff[MAX_KEYWORD-2:0], req_byte};
   assign count_plus   = count_ff + COUNT_W'(1);

   lrkm_match u_match (
      .window      (window_shift),
      .count       (count_plus),
      .cfg         (cfg),
      .keyword_hit (keyword_hit),
      .error_hit   (error_hit)
   );

   always_comb begin
      active_in   = active_ff;
      window_in   = window_ff;
      count_in    = count_ff;
      kw_seen_in  = kw_seen_ff;
      err_seen_in = err_seen_ff;
      nul_seen_in = nul_seen_ff;
      idle_in     = idle_ff;
      result_load = 1'b0;
      result_code = OUT_OK;
      if (req_accept) begin
         unique case (req_opcode)
            OP_START: begin
               window_in   = '0;
               count_in    = '0;
               kw_seen_in  = 1'b0;
               err_seen_in = 1'b0;
               nul_seen_in = 1'b0;
               idle_in     = '0;
               active_in   = 1'b1;
               if (cfg.timeout_ticks == '0) begin
                  active_in   = 1'b0;
                  result_load = 1'b1;
                  result_code = OUT_TIMEOUT;
               end
            end
            OP_BYTE: begin
               if (active_ff) begin
                  idle_in = '0;
                  if (req_byte == CHAR_LF) begin
                     if (cfg.keyword_enable
                           && (cfg.keyword_length == '0 || kw_seen_ff)) begin
                        active_in   = 1'b0;
                        result_load = 1'b1;
                        result_code = OUT_OK;
                     end else if (err_seen_ff) begin
                        active_in   = 1'b0;
                        result_load = 1'b1;
                        result_code = OUT_ERROR;
                     end else begin
                        window_in   = '0;
                        count_in    = '0;
                        kw_seen_in  = 1'b0;
                        err_seen_in = 1'b0;
                        nul_seen_in = 1'b0;
                     end
                  end else if (req_byte != CHAR_CR && count_ff < LINE_FULL) begin
                     count_in = count_plus;
                     if (!nul_seen_ff) begin
                        if (req_byte == CHAR_NUL) begin
                           nul_seen_in = 1'b1;
                        end else begin
                           window_in   = window_shift;
                           kw_seen_in  = kw_seen_ff | keyword_hit;
                           err_seen_in = err_seen_ff | error_hit;
                        end
                     end
                  end
               end
            end
            OP_TICK: begin
               if (active_ff) begin
                  if (idle_ff != '1) begin
                     idle_in = idle_ff + TICK_W'(1);
                  end
                  if (idle_in >= cfg.timeout_ticks) begin
                     active_in   = 1'b0;
                     result_load = 1'b1;
                     result_code = OUT_TIMEOUT;
                  end
               end
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      outcome_in = outcome_ff;
      if (result_load) begin
         valid_in   = 1'b1;
         outcome_in = result_code;
      end else if (rsp_taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         count_ff    <= '0;
         kw_seen_ff  <= 1'b0;
         err_seen_ff <= 1'b0;
         nul_seen_ff <= 1'b0;
         idle_ff     <= '0;
         valid_ff    <= 1'b0;
         window_ff   <= '0;
      end else begin
         active_ff   <= active_in;
         count_ff    <= count_in;
         kw_seen_ff  <= kw_seen_in;
         err_seen_ff <= err_seen_in;
         nul_seen_ff <= nul_seen_in;
         idle_ff     <= idle_in;
         valid_ff    <= valid_in;
         window_ff   <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      outcome_ff <= outcome_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_outcome         = outcome_ff;
   assign status.active       = active_ff;
   assign status.stored_count = count_ff;
   assign status.result_load  = result_load;

endmodule

// File: verif/tb_line_response_keyword_matcher.sv
// Testbench for line_response_keyword_matcher: directed lines and random sessions,
// checked against an in-bench prediction of the line and timeout behavior.
// Depends on lrkm_pkg and the RTL of the block only.
module tb_line_response_keyword_matcher;
   import lrkm_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 5;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_GAP        = 50;
   localparam int MAX_REPORTS    = 10;
   localparam logic [4:0][7:0] ERROR_TEXT = "ERROR";
   localparam logic [TICK_W-1:0] TICKS_MAX = '1;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [7:0] data_byte
   logic [1:0]             req_tuser;   // [1:0] opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;   // [1:0] outcome
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   line_response_keyword_matcher DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Predicted configuration and line state.
   logic [MAX_KEYWORD-1:0][7:0] kw_bytes;
   logic [KW_LEN_W-1:0]         kw_len_reg;
   logic                        kw_enable;
   logic [TICK_W-1:0]           timeout_limit;
   logic                        wait_active;
   logic [7:0]                  recent [MAX_KEYWORD];
   int                          line_count;
   logic                        kw_hit;
   logic                        err_hit;
   logic                        nul_hit;
   logic [TICK_W-1:0]           idle_count;

   outcome_type outcome_q [$];
   int          mismatches = 0;
   int          accepted_items = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_requests = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   string       letters = "ABEKOR";

   function automatic int eff_len();
      return (kw_len_reg > KW_LEN_MAX) ? MAX_KEYWORD : int'(kw_len_reg);
   endfunction

   task automatic clear_line();
      for (int i = 0; i < MAX_KEYWORD; i++) recent[i] = 8'h00;
      line_count = 0;
      kw_hit = 1'b0;
      err_hit = 1'b0;
      nul_hit = 1'b0;
   endtask

   task automatic store_char(input logic [7:0] c);
      int   len;
      logic hit;
      if (line_count >= LINE_CAPACITY - 1) return;
      line_count++;
      if (nul_hit) return;
      if (c == CHAR_NUL) begin
         nul_hit = 1'b1;
         return;
      end
      for (int i = MAX_KEYWORD - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = c;
      len = eff_len();
      if (len > 0 && line_count >= len) begin
         hit = 1'b1;
         for (int i = 0; i < len; i++)
            if (recent[len-1-i] != kw_bytes[i]) hit = 1'b0;
         if (hit) kw_hit = 1'b1;
      end
      if (line_count >= 5) begin
         hit = 1'b1;
         for (int i = 0; i < 5; i++)
            if (recent[i] != ERROR_TEXT[i]) hit = 1'b0;
         if (hit) err_hit = 1'b1;
      end
   endtask

   task automatic predict_outcome(input opcode_type op, input logic [7:0] c,
                                  output logic produced, output outcome_type res);
      produced = 1'b0;
      res = OUT_OK;
      if (op == OP_START) begin
         clear_line();
         idle_count = '0;
         wait_active = 1'b1;
         if (timeout_limit == '0) begin
            wait_active = 1'b0;
            produced = 1'b1;
            res = OUT_TIMEOUT;
         end
      end else if (wait_active) begin
         if (op == OP_BYTE) begin
            idle_count = '0;
            if (c == CHAR_LF) begin
               if (kw_enable && (eff_len() == 0 || kw_hit)) begin
                  wait_active = 1'b0;
                  produced = 1'b1;
                  res = OUT_OK;
               end else if (err_hit) begin
                  wait_active = 1'b0;
                  produced = 1'b1;
                  res = OUT_ERROR;
               end else begin
                  clear_line();
               end
            end else if (c != CHAR_CR) begin
               store_char(c);
            end
         end else if (op == OP_TICK) begin
            if (idle_count != TICKS_MAX) idle_count++;
            if (idle_count >= timeout_limit) begin
               wait_active = 1'b0;
               produced = 1'b1;
               res = OUT_TIMEOUT;
            end
         end
      end
   endtask

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endtask

   // Every transfer is observed at the rising edge, before the block updates.
   always @(posedge clock) begin
      logic        produced;
      outcome_type res;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_KEYWORD_LOW:  kw_bytes[7:0] = csr_data;
               REG_KEYWORD_HIGH: kw_bytes[15:8] = csr_data;
               REG_KEYWORD_LEN:  kw_len_reg = csr_data[KW_LEN_W-1:0];
               REG_KEYWORD_EN:   kw_enable = csr_data[0];
               REG_TIMEOUT:      timeout_limit = csr_data[TICK_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0)
               note_mismatch($sformatf("unexpected outcome %0d", rsp_tdata[1:0]));
            else begin
               res = outcome_q.pop_front();
               if (rsp_tdata[1:0] != res)
                  note_mismatch($sformatf("outcome mismatch: expected %0d, got %0d",
                                          res, rsp_tdata[1:0]));
            end
         end
         if (req_tvalid && req_tready) begin
            if (opcode_type'(req_tuser) == OP_START || wait_active) accepted_items++;
            predict_outcome(opcode_type'(req_tuser), req_tdata, produced, res);
            if (produced) outcome_q.push_back(res);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(input opcode_type op, input logic [7:0] c);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= c;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Ends any running wait, lets the block settle, then writes all registers.
   task automatic apply_config(input logic [63:0] low, input logic [63:0] high,
                               input int len, input bit en, input logic [31:0] ticks);
      if (wait_active) send_item(OP_BYTE, CHAR_LF);
      if (wait_active) send_text("ERROR\n");
      drain_results();
      write_reg(REG_KEYWORD_LOW, low);
      write_reg(REG_KEYWORD_HIGH, high);
      write_reg(REG_KEYWORD_LEN, {32'($urandom()), 27'($urandom()), 5'(len)});
      write_reg(REG_KEYWORD_EN, {32'($urandom()), 31'($urandom()), en});
      write_reg(REG_TIMEOUT, {32'($urandom()), ticks});
      csr_valid <= 1'b0;
   endtask

   task automatic emit_line();
      int n;
      int r;
      int kl;
      n = ($urandom_range(59) == 0) ? $urandom_range(530, 505) : $urandom_range(12);
      for (int i = 0; i < n && wait_active; i++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            kl = ($urandom_range(3) == 0) ? $urandom_range(eff_len()) : eff_len();
            for (int k = 0; k < kl && wait_active; k++) send_item(OP_BYTE, kw_bytes[k]);
         end else if (r < 13) send_text("ERROR");
         else if (r < 20) send_item(OP_BYTE, CHAR_CR);
         else if (r < 23) send_item(OP_BYTE, CHAR_NUL);
         else if (r < 33) send_item(OP_TICK, 8'($urandom_range(255)));
         else if (r < 36) send_item(OP_BYTE, 8'($urandom_range(255)));
         else if (r < 38) send_item(OP_NONE, 8'($urandom_range(255)));
         else if (r < 39) send_item(OP_START, 8'($urandom_range(255)));
         else send_item(OP_BYTE, letters[$urandom_range(letters.len() - 1)]);
      end
      if (wait_active) send_item(OP_BYTE, CHAR_LF);
   endtask

   task automatic run_session();
      int lines;
      int burst;
      send_item(OP_START, 8'($urandom_range(255)));
      lines = 0;
      while (wait_active && lines < 8) begin
         emit_line();
         if ($urandom_range(5) == 0) begin
            burst = $urandom_range(30, 1);
            for (int i = 0; i < burst && wait_active; i++)
               send_item(OP_TICK, 8'($urandom_range(255)));
         end
         lines++;
      end
      repeat ($urandom_range(2))
         send_item(opcode_type'($urandom_range(3)), 8'($urandom_range(255)));
   endtask

   task automatic test_defaults();
      send_idle_pct = 0;
      stall_pct = 0;
      send_item(OP_BYTE, "A");
      send_item(OP_TICK, 8'h00);
      send_item(OP_NONE, 8'hFF);
      send_item(OP_START, 8'h00);
      send_text("ERROR\n");
   endtask

   task automatic test_keyword_match();
      apply_config(64'h4B4F, {$urandom(), $urandom()}, 2, 1'b1, 32'd3);
      send_item(OP_START, 8'h00);
      send_text("O\rK\n");
      send_item(OP_START, 8'h00);
      repeat (3) send_item(OP_TICK, 8'h00);
   endtask

   task automatic test_line_rules();
      apply_config('1, '1, 0, 1'b1, 32'd0);
      send_item(OP_START, 8'hFF);
      apply_config({$urandom(), $urandom()}, {$urandom(), $urandom()}, 0, 1'b0, TICKS_MAX);
      send_item(OP_START, 8'h00);
      send_text("X\n");
      send_item(OP_BYTE, CHAR_NUL);
      send_text("ERROR\nERROR\n");
      apply_config('0, '0, 0, 1'b1, TICKS_MAX);
      send_item(OP_START, 8'h00);
      send_item(OP_BYTE, CHAR_LF);
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int len, input logic [31:0] ticks,
                                      input int n);
      logic [MAX_KEYWORD-1:0][7:0] kw;
      int target;
      for (int k = 0; k < MAX_KEYWORD; k++)
         kw[k] = ($urandom_range(5) == 0) ? 8'($urandom_range(255))
                                          : letters[$urandom_range(letters.len() - 1)];
      if ($urandom_range(7) == 0) kw[$urandom_range(MAX_KEYWORD - 1)] = CHAR_NUL;
      apply_config(kw[7:0], kw[15:8], len, $urandom_range(3) != 0, ticks);
      send_idle_pct = sender_pct;
      stall_pct = receiver_pct;
      target = accepted_items + n;
      while (accepted_items < target) run_session();
   endtask

   task automatic test_backpressure();
      apply_config({$urandom(), $urandom()}, {$urandom(), $urandom()}, 4, 1'b1, 32'd5);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (12) begin
         send_item(OP_START, 8'h00);
         send_text("ERROR\n");
         repeat (5) send_item(OP_TICK, 8'h00);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      kw_bytes = '0;
      kw_len_reg = KW_LEN_W'(2);
      kw_enable = 1'b1;
      timeout_limit = TICK_W'(1000);
      wait_active = 1'b0;
      idle_count = '0;
      clear_line();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_defaults();
      test_keyword_match();
      test_line_rules();
      test_random_traffic(0, 0, 3, 32'd25, 420);
      test_random_traffic(62, 0, 16, TICKS_MAX, 420);
      test_random_traffic(0, 62, 31, 32'd12, 420);
      test_random_traffic(19, 19, 1, 32'd40, 420);
      test_backpressure();

      drain_results();
      if (outcome_q.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
